>>> design/negacyclic_poly_mul_add_top_defines.svh
// ----------------------------------------------------------------------------
// negacyclic_poly_mul_add_top_defines.svh
// Assertion macros shared by the negacyclic multiply-add design.
// ----------------------------------------------------------------------------
`ifndef NEGACYCLIC_POLY_MUL_ADD_TOP_DEFINES_SVH
`define NEGACYCLIC_POLY_MUL_ADD_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define NPMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("npma: same-cycle check failed");
// next-cycle implication
`define NPMA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("npma: next-cycle check failed");
`else
`define NPMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define NPMA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> design/npma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npma_pkg
// Types, codes and helpers for the negacyclic multiply-add block.
// ----------------------------------------------------------------------------
package npma_pkg;

  localparam int IDX_W  = 9;
  localparam int COEF_W = 8;
  localparam int S_W    = 2;
  localparam int TAB_N  = 1 << COEF_W;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_PUSH = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // secret coefficient as sign and magnitude, so that -(-2) fits
  typedef struct packed {
    logic       neg;
    logic [1:0] mag;
  } rot_t;

  // broadcast from the control stage to every cell
  typedef struct packed {
    logic              push;
    logic              restore;
    logic [COEF_W-1:0] amod;
    logic [COEF_W-1:0] a2mod;
  } cell_ctl_t;

  function automatic rot_t s_to_rot(input logic signed [S_W-1:0] s);
    rot_t r;
    r = '{neg: 1'b0, mag: 2'd0};
    case (s)
      2'sb01:  r = '{neg: 1'b0, mag: 2'd1};
      2'sb11:  r = '{neg: 1'b1, mag: 2'd1};
      2'sb10:  r = '{neg: 1'b1, mag: 2'd2};
      default: r = '{neg: 1'b0, mag: 2'd0};
    endcase
    return r;
  endfunction

endpackage

>>> design/npma_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module npma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/npma_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npma_cell
// One accumulator cell: holds a secret coefficient, its rotated copy and a
// running sum mod MODULUS; passes the rotated copy to its neighbor on push.
// ----------------------------------------------------------------------------
module npma_cell #(
  parameter int MODULUS = 251
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  npma_pkg::cell_ctl_t           ctl,
  input  logic                          sel,
  input  npma_pkg::rot_t                s_new,
  input  npma_pkg::rot_t                rot_in,
  output npma_pkg::rot_t                rot_out,
  output logic [npma_pkg::COEF_W-1:0]   acc_out
);

  localparam logic [npma_pkg::COEF_W:0] MOD_X = (npma_pkg::COEF_W + 1)'(MODULUS);

  npma_pkg::rot_t                sec_r;
  npma_pkg::rot_t                rot_r;
  logic [npma_pkg::COEF_W-1:0]   acc_r;
  logic [npma_pkg::COEF_W-1:0]   acc_nxt;
  logic [npma_pkg::COEF_W-1:0]   term;
  logic [npma_pkg::COEF_W:0]     sum;
  logic [npma_pkg::COEF_W:0]     diff;

  always_comb begin
    case (rot_r.mag)
      2'd1:    term = ctl.amod;
      2'd2:    term = ctl.a2mod;
      default: term = '0;
    endcase
    sum  = {1'b0, acc_r} + {1'b0, term};
    diff = {1'b0, acc_r} - {1'b0, term};
    if (rot_r.neg) begin
      // borrow: wrap back into [0, MODULUS)
      if (acc_r < term) begin
        diff = diff + MOD_X;
      end
      acc_nxt = diff[npma_pkg::COEF_W-1:0];
    end else begin
      if (sum >= MOD_X) begin
        sum = sum - MOD_X;
      end
      acc_nxt = sum[npma_pkg::COEF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (sel) begin
      acc_r <= '0;
    end else if (ctl.push) begin
      acc_r <= acc_nxt;
    end
  end

  // secret stores are undefined until loaded
  always_ff @(posedge clk) begin
    if (sel) begin
      sec_r <= s_new;
      rot_r <= s_new;
    end else if (ctl.restore) begin
      rot_r <= sec_r;
    end else if (ctl.push) begin
      rot_r <= rot_in;
    end
  end

  assign rot_out = rot_r;
  assign acc_out = acc_r;

endmodule

>>> design/negacyclic_poly_mul_add_top.sv
`timescale 1ns / 1ps
// Load and push transfers: one per cycle unless a read holds off the input, applied to the cell row in the cycle after.
// Read transfers: the command, then the accumulator select and error RAM read, then the
//   result are registered; the input is held off while the select and read are in flight.
// Push cost does not grow with DEGREE: all cells update together.
// Reset (rst_n, synchronous, active low) clears accumulators, push count and
//   pipeline; secret and error stores are undefined until loaded.
// ----------------------------------------------------------------------------
// negacyclic_poly_mul_add_top
// (a*s + e) mod (x^DEGREE + 1, MODULUS) over a row of accumulator cells.
// ----------------------------------------------------------------------------
`include "negacyclic_poly_mul_add_top_defines.svh"

module negacyclic_poly_mul_add_top #(
  parameter int DEGREE  = 512,
  parameter int MODULUS = 251
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_op,
  input  logic [npma_pkg::IDX_W-1:0]          in_index,
  input  logic signed [npma_pkg::S_W-1:0]     in_s_coef,
  input  logic [npma_pkg::COEF_W-1:0]         in_e_coef,
  input  logic [npma_pkg::COEF_W-1:0]         in_a_coef,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [npma_pkg::COEF_W-1:0]         out_coef
);

  localparam int AW = $clog2(DEGREE);
  localparam int XW = AW + npma_pkg::IDX_W;
  localparam int CW = $clog2(DEGREE + 1);
  localparam int CWD = npma_pkg::COEF_W;
  localparam logic [CWD:0] MOD_X = (CWD + 1)'(MODULUS);

  // reduction tables for a mod Q, 2a mod Q (also used for e mod Q)
  logic [CWD-1:0] amod_tab  [npma_pkg::TAB_N];
  logic [CWD-1:0] a2mod_tab [npma_pkg::TAB_N];

  for (genvar v = 0; v < npma_pkg::TAB_N; v++) begin : g_tab
    localparam int RV1 = v % MODULUS;
    localparam int RV2 = (2 * v) % MODULUS;
    assign amod_tab[v]  = CWD'(RV1);
    assign a2mod_tab[v] = CWD'(RV2);
  end

  // stage 1: registered command
  logic                  s1_vld_r;
  npma_pkg::op_t         s1_op_r;
  logic                  s1_inr_r;
  logic [AW-1:0]         s1_idx_r;
  npma_pkg::rot_t        s1_s_r;
  logic [CWD-1:0]        s1_e_r;
  logic [CWD-1:0]        s1_a_r;
  logic [CWD-1:0]        s1_a2_r;

  logic                  in_xfer;
  logic [XW-1:0]         idx_x;
  logic                  idx_inr;

  assign in_xfer = in_valid && in_ready;
  assign idx_x   = XW'(in_index);
  assign idx_inr = {{(32 - npma_pkg::IDX_W){1'b0}}, in_index} < 32'(DEGREE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r  <= npma_pkg::op_t'(in_op);
      s1_inr_r <= idx_inr;
      s1_idx_r <= idx_x[AW-1:0];
      s1_s_r   <= npma_pkg::s_to_rot(in_s_coef);
      s1_e_r   <= amod_tab[in_e_coef];
      s1_a_r   <= amod_tab[in_a_coef];
      s1_a2_r  <= a2mod_tab[in_a_coef];
    end
  end

  logic [CW-1:0] cnt_r;
  logic          s1_load_ok;
  logic          s1_push_ok;
  logic          s1_rd;

  assign s1_load_ok = s1_vld_r && (s1_op_r == npma_pkg::OP_LOAD) && s1_inr_r;
  assign s1_push_ok = s1_vld_r && (s1_op_r == npma_pkg::OP_PUSH) && (cnt_r < CW'(DEGREE));
  assign s1_rd      = s1_vld_r && (s1_op_r == npma_pkg::OP_READ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (s1_load_ok) begin
      cnt_r <= '0;
    end else if (s1_push_ok) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // cell row
  npma_pkg::cell_ctl_t ctl;
  npma_pkg::rot_t      rot_w [DEGREE];
  npma_pkg::rot_t      rot_wrap;
  logic [CWD-1:0]      acc_w [DEGREE];

  assign ctl = '{push: s1_push_ok, restore: s1_load_ok, amod: s1_a_r, a2mod: s1_a2_r};
  // x^DEGREE = -1: the entry leaving the top comes back negated
  assign rot_wrap = '{neg: !rot_w[DEGREE-1].neg, mag: rot_w[DEGREE-1].mag};

  for (genvar k = 0; k < DEGREE; k++) begin : g_cell
    npma_pkg::rot_t rot_in_k;
    logic           sel_k;
    if (k == 0) begin : g_first
      assign rot_in_k = rot_wrap;
    end else begin : g_rest
      assign rot_in_k = rot_w[k-1];
    end
    assign sel_k = s1_load_ok && (s1_idx_r == AW'(k));

    npma_cell #(
      .MODULUS(MODULUS)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .sel    (sel_k),
      .s_new  (s1_s_r),
      .rot_in (rot_in_k),
      .rot_out(rot_w[k]),
      .acc_out(acc_w[k])
    );
  end

  // error store, reduced mod Q on the way in
  logic [CWD-1:0] e_rd;

  npma_ram #(
    .WIDTH(CWD),
    .DEPTH(DEGREE)
  ) u_err_ram (
    .clk    (clk),
    .wr_en  (s1_load_ok),
    .wr_addr(s1_idx_r),
    .wr_data(s1_e_r),
    .rd_en  (s1_rd),
    .rd_addr(s1_idx_r),
    .rd_data(e_rd)
  );

  // stage 2: selected accumulator, then final add and output register
  logic           s2_vld_r;
  logic           s2_oor_r;
  logic [CWD-1:0] s2_acc_r;
  logic           out_vld_r;
  logic [CWD-1:0] out_coef_r;
  logic [CWD-1:0] out_coef_nxt;
  logic [CWD:0]   res_sum;
  logic           s2_go;

  assign s2_go = s2_vld_r && (!out_vld_r || out_ready);

  always_comb begin
    res_sum = {1'b0, s2_acc_r} + {1'b0, e_rd};
    if (res_sum >= MOD_X) begin
      res_sum = res_sum - MOD_X;
    end
    out_coef_nxt = s2_oor_r ? '0 : res_sum[CWD-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s1_rd) begin
        s2_vld_r <= 1'b1;
      end else if (s2_go) begin
        s2_vld_r <= 1'b0;
      end
      if (s2_go) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rd) begin
      s2_acc_r <= acc_w[s1_idx_r];
      s2_oor_r <= !s1_inr_r;
    end
    if (s2_go) begin
      out_coef_r <= out_coef_nxt;
    end
  end

  assign in_ready  = !s1_rd && !s2_vld_r;
  assign out_valid = out_vld_r;
  assign out_coef  = out_coef_r;

  `NPMA_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(DEGREE))
  `NPMA_ASSERT_NXT(a_rd_to_s2, clk, rst_n, s1_rd, s2_vld_r)
  `NPMA_ASSERT_IMP(a_rd_holds_in, clk, rst_n, s1_rd || s2_vld_r, !in_ready)
  `NPMA_ASSERT_IMP(a_out_range, clk, rst_n, out_vld_r, {1'b0, out_coef_r} < MOD_X)
  `NPMA_ASSERT_NXT(a_load_clears, clk, rst_n, s1_load_ok, cnt_r == '0)

endmodule

>>> bench/npma_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npma_checker
// Watches the input and result channels of the negacyclic multiply-add
// block, keeps its own secret, error and accumulator rows, and checks every
// read result in order against the predicted coefficient.
// ----------------------------------------------------------------------------
module npma_checker #(
  parameter int DEGREE  = 512,
  parameter int MODULUS = 251
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [1:0]                          in_op,
  input  logic [npma_pkg::IDX_W-1:0]          in_index,
  input  logic signed [npma_pkg::S_W-1:0]     in_s_coef,
  input  logic [npma_pkg::COEF_W-1:0]         in_e_coef,
  input  logic [npma_pkg::COEF_W-1:0]         in_a_coef,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [npma_pkg::COEF_W-1:0]         out_coef,
  output int unsigned                         coefs_owed,
  output int unsigned                         fail_count
);
  import npma_pkg::*;

  logic signed [S_W-1:0] secret_mem [DEGREE];
  logic [COEF_W-1:0]     error_mem  [DEGREE];
  logic [COEF_W-1:0]     acc_row    [DEGREE];
  int unsigned           a_taken;
  logic [COEF_W-1:0]     expected_coefs [$];
  logic [COEF_W-1:0]     want;
  int unsigned           sum;
  int unsigned           mismatches;

  initial begin
    foreach (secret_mem[k]) begin
      secret_mem[k] = '0;
      error_mem[k]  = '0;
      acc_row[k]    = '0;
    end
    a_taken    = 0;
    mismatches = 0;
    coefs_owed = 0;
    fail_count = 0;
  end

  // one a coefficient against the negacyclically rotated secret, all cells
  task automatic accumulate_row(input logic [COEF_W-1:0] a);
    int unsigned ar;
    int unsigned mag;
    int unsigned src;
    int unsigned v;
    int          sv;
    int          k;
    bit          wrap;
    bit          neg;
    if (a_taken < DEGREE) begin
      ar = a % MODULUS;
      for (k = 0; k < DEGREE; k++) begin
        wrap = (k < a_taken);
        src  = wrap ? k + DEGREE - a_taken : k - a_taken;
        sv   = secret_mem[src];
        if (sv != 0) begin
          mag = (ar * (sv < 0 ? -sv : sv)) % MODULUS;
          // x^DEGREE = -1: terms that wrap flip sign
          neg = (sv < 0) ^ wrap;
          v   = acc_row[k];
          v   = neg ? (v + MODULUS - mag) % MODULUS : (v + mag) % MODULUS;
          acc_row[k] = v[COEF_W-1:0];
        end
      end
      a_taken++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (acc_row[k]) acc_row[k] = '0;
      a_taken = 0;
      expected_coefs.delete();
    end else begin
      // results leave before this edge's read can produce one
      if (out_valid && out_ready) begin
        if (expected_coefs.size() == 0) begin
          $error("coef: result with no read outstanding, expected none, actual %0d", out_coef);
          mismatches++;
        end else begin
          want = expected_coefs.pop_front();
          if (out_coef !== want) begin
            $error("coef mismatch: expected %0d, actual %0d", want, out_coef);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        case (op_t'(in_op))
          OP_LOAD: begin
            if (in_index < DEGREE) begin
              secret_mem[in_index] = in_s_coef;
              error_mem[in_index]  = in_e_coef;
              acc_row[in_index]    = '0;
              a_taken = 0;
            end
          end
          OP_PUSH: accumulate_row(in_a_coef);
          OP_READ: begin
            if (in_index < DEGREE) begin
              sum  = int'(acc_row[in_index]) + int'(error_mem[in_index]);
              sum  = sum % MODULUS;
              want = sum[COEF_W-1:0];
            end else begin
              want = '0;
            end
            expected_coefs.push_back(want);
          end
          default: ;
        endcase
      end
    end
    coefs_owed <= expected_coefs.size();
    fail_count <= mismatches;
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the negacyclic multiply-add block: fills every secret and
// error entry, runs a short directed pass, then random runs of loads, pushes
// and reads with random stalls on both channels. The checker does the rest.
// ----------------------------------------------------------------------------
module testbench;
  import npma_pkg::*;

  localparam int DEGREE    = 512;
  localparam int MODULUS   = 251;
  localparam int NUM_ITEMS = 1750;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_op;
  logic [IDX_W-1:0]      in_index;
  logic signed [S_W-1:0] in_s_coef;
  logic [COEF_W-1:0]     in_e_coef;
  logic [COEF_W-1:0]     in_a_coef;
  logic                  out_valid;
  logic                  out_ready;
  logic [COEF_W-1:0]     out_coef;
  int unsigned           coefs_owed;
  int unsigned           fail_count;

  bit                    calm;
  int unsigned           idle_pct;
  int unsigned           pushes_run;
  int unsigned           live_items;

  negacyclic_poly_mul_add_top #(
    .DEGREE  (DEGREE),
    .MODULUS (MODULUS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_index  (in_index),
    .in_s_coef (in_s_coef),
    .in_e_coef (in_e_coef),
    .in_a_coef (in_a_coef),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_coef  (out_coef)
  );

  npma_checker #(
    .DEGREE  (DEGREE),
    .MODULUS (MODULUS)
  ) coef_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_index   (in_index),
    .in_s_coef  (in_s_coef),
    .in_e_coef  (in_e_coef),
    .in_a_coef  (in_a_coef),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_coef   (out_coef),
    .coefs_owed (coefs_owed),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // one transfer; unused payload fields are random at the call site
  task automatic issue(input op_t op, input logic [IDX_W-1:0] idx,
                       input logic signed [S_W-1:0] s, input logic [COEF_W-1:0] e,
                       input logic [COEF_W-1:0] a);
    in_valid  <= 1'b1;
    in_op     <= op;
    in_index  <= idx;
    in_s_coef <= s;
    in_e_coef <= e;
    in_a_coef <= a;
    do @(posedge clk); while (!in_ready);
    if (op != OP_NONE && !(op == OP_PUSH && pushes_run >= DEGREE)) live_items++;
    if (op == OP_LOAD) pushes_run = 0;
    else if (op == OP_PUSH && pushes_run < DEGREE) pushes_run++;
    if (live_items + 150 >= NUM_ITEMS) calm = 1'b1;
    if (!calm && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // result side: ready bursts with random stalls between them
  initial begin
    out_ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin
    int                    i;
    int unsigned           ep;
    int unsigned           nloads;
    int unsigned           npush;
    int unsigned           pick;
    bit                    long_run;
    logic signed [S_W-1:0] s;
    logic [COEF_W-1:0]     e;

    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_op      <= OP_NONE;
    in_index   <= '0;
    in_s_coef  <= '0;
    in_e_coef  <= '0;
    in_a_coef  <= '0;
    calm       = 1'b0;
    idle_pct   = 20;
    pushes_run = 0;
    live_items = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every push touches every secret entry, so all of them are written first
    for (i = 0; i < DEGREE; i++) begin
      case (i)
        0:          begin s = -2'sd2; e = 8'd255; end
        1:          begin s = 2'sd1;  e = 8'd251; end
        2:          begin s = -2'sd1; e = 8'd250; end
        DEGREE - 1: begin s = 2'sd1;  e = 8'd0;   end
        default:    begin s = $urandom; e = $urandom; end
      endcase
      issue(OP_LOAD, i, s, e, $urandom);
    end

    // directed: error above modulus, extreme a values, unused op, load mid-run
    issue(OP_READ, 0, $urandom, $urandom, $urandom);
    issue(OP_READ, 1, $urandom, $urandom, $urandom);
    issue(OP_READ, DEGREE - 1, $urandom, $urandom, $urandom);
    issue(OP_NONE, $urandom, $urandom, $urandom, $urandom);
    issue(OP_PUSH, $urandom, $urandom, $urandom, 8'd255);
    issue(OP_PUSH, $urandom, $urandom, $urandom, 8'd251);
    issue(OP_PUSH, $urandom, $urandom, $urandom, 8'd250);
    issue(OP_PUSH, $urandom, $urandom, $urandom, 8'd0);
    issue(OP_PUSH, $urandom, $urandom, $urandom, 8'd1);
    issue(OP_READ, 0, $urandom, $urandom, $urandom);
    issue(OP_READ, 2, $urandom, $urandom, $urandom);
    issue(OP_READ, 5, $urandom, $urandom, $urandom);
    issue(OP_READ, DEGREE - 1, $urandom, $urandom, $urandom);
    issue(OP_NONE, $urandom, $urandom, $urandom, $urandom);
    issue(OP_LOAD, 5, -2'sd2, 8'd200, $urandom);
    issue(OP_PUSH, $urandom, $urandom, $urandom, 8'd255);
    issue(OP_PUSH, $urandom, $urandom, $urandom, 8'd128);
    issue(OP_READ, 5, $urandom, $urandom, $urandom);
    issue(OP_READ, 4, $urandom, $urandom, $urandom);
    issue(OP_READ, 6, $urandom, $urandom, $urandom);
    issue(OP_READ, DEGREE - 1, $urandom, $urandom, $urandom);

    // random runs; every fourth one goes past a full set of pushes while
    // the item budget still has room for it
    ep = 0;
    while (live_items < NUM_ITEMS) begin
      long_run = (ep % 4 == 0) && (live_items + 700 < NUM_ITEMS);
      idle_pct = (ep % 3 == 1) ? 0 : ((ep % 3 == 2) ? 40 : 12);
      nloads   = long_run ? $urandom_range(1, 4) : $urandom_range(0, 6);
      repeat (nloads) issue(OP_LOAD, $urandom, $urandom, $urandom, $urandom);
      npush = long_run ? DEGREE + $urandom_range(1, 12) : $urandom_range(1, 40);
      while (npush > 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          issue(OP_READ, $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 24) begin
          issue(OP_NONE, $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 26 && !long_run) begin
          // a load in the middle restarts the push sequence
          issue(OP_LOAD, $urandom, $urandom, $urandom, $urandom);
        end else begin
          issue(OP_PUSH, $urandom, $urandom, $urandom, $urandom);
          npush--;
        end
      end
      repeat ($urandom_range(1, 6)) issue(OP_READ, $urandom, $urandom, $urandom, $urandom);
      ep++;
    end
    in_valid <= 1'b0;

    while (coefs_owed != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fail_count == 0 && coefs_owed == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
